@@ src/vds_pkg.sv @@
// ----------------------------------------------------------------------------
// vds_pkg
// Widths, metric codes and the control structs shared by the distance engine.
// ----------------------------------------------------------------------------
`default_nettype none

package vds_pkg;

   localparam int ELEM_W = 16;
   localparam int MODE_W = 2;
   localparam int DIST_W = 26;
   localparam int SIM_W  = 18;
   localparam int MAIN_W = 48;
   localparam int SQ_W   = 41;
   localparam int ALU_W  = 84;
   localparam int ROOT_W = 42;

   localparam logic [MODE_W-1:0] MODE_NORM      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EUCLIDEAN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MANHATTAN = 2'd2;
   localparam logic [MODE_W-1:0] MODE_COSINE    = 2'd3;

   localparam logic [SQ_W-1:0]   SQ_MAX   = {SQ_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [16:0]       ONE_Q16  = 17'h10000;

   typedef struct packed {
      logic              start;
      logic [MODE_W-1:0] mode;
   } fin_req_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] distance;
      logic [SIM_W-1:0]  similarity;
      logic              zero_norm;
   } fin_rsp_type;

endpackage

`default_nettype wire

@@ src/vds_accum.sv @@
// ----------------------------------------------------------------------------
// vds_accum
// Element accumulator: one shared 17x17 multiplier forms a*a, b*b and each product term.
// ----------------------------------------------------------------------------
`default_nettype none

module vds_accum #(
   parameter int ELEM_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              clear,
   input  wire logic [vds_pkg::MODE_W-1:0]        mode,
   input  wire logic signed [vds_pkg::ELEM_W-1:0] elem_a,
   input  wire logic signed [vds_pkg::ELEM_W-1:0] elem_b,
   output logic                                   done,
   output logic signed [vds_pkg::MAIN_W-1:0]      main_sum,
   output logic [vds_pkg::SQ_W-1:0]               square_sum_a,
   output logic [vds_pkg::SQ_W-1:0]               square_sum_b
);

   localparam int EB = (ELEM_BITS < 16) ? ELEM_BITS : 16;

   logic signed [16:0] a_ff, b_ff, a_in, b_in, diff, abs_diff, mul_x, mul_y;
   logic signed [33:0] prod_ff, prod_in;
   logic [vds_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [vds_pkg::MAIN_W-1:0] main_ff, main_in;
   logic [vds_pkg::SQ_W-1:0] sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [vds_pkg::SQ_W:0] sq_sum;
   logic [vds_pkg::MAIN_W:0] main_add;

   assign diff     = a_ff - b_ff;
   assign abs_diff = diff[16] ? -diff : diff;

   always_comb begin
      mul_x = a_ff;
      mul_y = a_ff;
      case (step_ff)
         2'd1: begin
            mul_x = b_ff;
            mul_y = b_ff;
         end
         2'd2: begin
            mul_x = (mode_ff == vds_pkg::MODE_EUCLIDEAN) ? diff : a_ff;
            mul_y = (mode_ff == vds_pkg::MODE_EUCLIDEAN) ? diff : b_ff;
         end
         default: begin
            mul_x = a_ff;
            mul_y = a_ff;
         end
      endcase
   end

   assign sq_sum   = {1'b0, (step_ff == 2'd1) ? sqa_ff : sqb_ff} + {8'b0, prod_ff[33:0]};
   assign main_add = {main_ff[vds_pkg::MAIN_W-1], main_ff} + {{15{prod_ff[33]}}, prod_ff};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      mode_in = mode_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      main_in = main_ff;
      sqa_in  = sqa_ff;
      sqb_in  = sqb_ff;
      if (start) begin
         a_in    = {{(17 - EB){elem_a[EB-1]}}, elem_a[EB-1:0]};
         b_in    = {{(17 - EB){elem_b[EB-1]}}, elem_b[EB-1:0]};
         mode_in = mode;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2 && mode_ff == vds_pkg::MODE_MANHATTAN) begin
            prod_in = {17'b0, abs_diff};
         end else begin
            prod_in = mul_x * mul_y;
         end
         case (step_ff)
            2'd1: sqa_in = sq_sum[vds_pkg::SQ_W] ? vds_pkg::SQ_MAX : sq_sum[vds_pkg::SQ_W-1:0];
            2'd2: sqb_in = sq_sum[vds_pkg::SQ_W] ? vds_pkg::SQ_MAX : sq_sum[vds_pkg::SQ_W-1:0];
            2'd3: begin
               // Saturate when the two top bits of the sum disagree.
               if (main_add[vds_pkg::MAIN_W] != main_add[vds_pkg::MAIN_W-1]) begin
                  main_in = main_add[vds_pkg::MAIN_W] ?
                            {1'b1, {(vds_pkg::MAIN_W-1){1'b0}}} :
                            {1'b0, {(vds_pkg::MAIN_W-1){1'b1}}};
               end else begin
                  main_in = main_add[vds_pkg::MAIN_W-1:0];
               end
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: ;
         endcase
      end
      if (clear) begin
         main_in = '0;
         sqa_in  = '0;
         sqb_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      mode_ff <= mode_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         main_ff <= '0;
         sqa_ff  <= '0;
         sqb_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         main_ff <= main_in;
         sqa_ff  <= sqa_in;
         sqb_ff  <= sqb_in;
      end
   end

   assign done         = done_ff;
   assign main_sum     = main_ff;
   assign square_sum_a = sqa_ff;
   assign square_sum_b = sqb_ff;

endmodule

`default_nettype wire

@@ src/vds_finish.sv @@
// ----------------------------------------------------------------------------
// vds_finish
// Result unit: one shared add/subtract datapath runs shift-add multiply,
// digit-by-digit square root and restoring division under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module vds_finish (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire vds_pkg::fin_req_type              fin_req,
   input  wire logic signed [vds_pkg::MAIN_W-1:0] main_sum,
   input  wire logic [vds_pkg::SQ_W-1:0]          square_sum_a,
   input  wire logic [vds_pkg::SQ_W-1:0]          square_sum_b,
   output vds_pkg::fin_rsp_type                   fin_rsp
);

   localparam int AW = vds_pkg::ALU_W;
   localparam int RW = vds_pkg::ROOT_W;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_SQRT = 4'b0100,
      F_DIV  = 4'b1000
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [AW-1:0] acc_ff, acc_in, rad_ff, rad_in, op_a, op_b;
   logic [AW:0] alu_sum;
   logic alu_sub, alu_ok, sticky_ff, sticky_in, neg_ff, neg_in, q_big;
   logic [RW-1:0] root_ff, root_in, den_ff, den_in, root_next;
   logic [vds_pkg::MAIN_W-1:0] mag_ff, mag_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [vds_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic done_ff, done_in, zn_ff, zn_in;
   logic [vds_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [vds_pkg::SIM_W-1:0] sim_ff, sim_in;
   logic [16:0] q_clamp;
   logic main_pos;

   // The one shared adder; subtraction reports no borrow through the carry.
   always_comb begin
      op_a    = {acc_ff[AW-2:0], rad_ff[AW-1]};
      op_b    = '0;
      alu_sub = 1'b1;
      case (state_ff)
         F_MUL: begin
            op_a    = {acc_ff[AW-2:0], 1'b0};
            op_b    = rad_ff[AW-1] ? {{(AW - RW){1'b0}}, den_ff} : '0;
            alu_sub = 1'b0;
         end
         F_SQRT: begin
            op_a = {acc_ff[AW-3:0], rad_ff[AW-1:AW-2]};
            op_b = {{(AW - RW - 2){1'b0}}, root_ff, 2'b01};
         end
         F_DIV: begin
            op_b = {{(AW - RW){1'b0}}, den_ff};
         end
         default: ;
      endcase
   end

   assign alu_sum   = {1'b0, op_a} + {1'b0, alu_sub ? ~op_b : op_b} + {{AW{1'b0}}, alu_sub};
   assign alu_ok    = alu_sum[AW];
   assign root_next = {root_ff[RW-2:0], alu_ok};
   assign main_pos  = !main_sum[vds_pkg::MAIN_W-1] && (main_sum != '0);
   assign q_big     = sticky_ff || root_ff[RW-1] || (root_next > RW'(vds_pkg::ONE_Q16));
   assign q_clamp   = q_big ? vds_pkg::ONE_Q16 : root_next[16:0];

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      den_in    = den_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      sticky_in = sticky_ff;
      cnt_in    = cnt_ff - 6'd1;
      mode_in   = mode_ff;
      done_in   = 1'b0;
      zn_in     = zn_ff;
      dist_in   = dist_ff;
      sim_in    = sim_ff;
      case (state_ff)
         F_IDLE: begin
            cnt_in = cnt_ff;
            if (fin_req.start) begin
               mode_in = fin_req.mode;
               acc_in  = '0;
               root_in = '0;
               zn_in   = 1'b0;
               dist_in = '0;
               sim_in  = '0;
               neg_in  = main_sum[vds_pkg::MAIN_W-1];
               mag_in  = main_sum[vds_pkg::MAIN_W-1] ? -main_sum : main_sum;
               case (fin_req.mode)
                  vds_pkg::MODE_NORM: begin
                     rad_in   = {7'b0, square_sum_a, 36'b0};
                     cnt_in   = 6'd23;
                     state_in = F_SQRT;
                  end
                  vds_pkg::MODE_EUCLIDEAN: begin
                     rad_in = {main_sum, 36'b0};
                     cnt_in = 6'd23;
                     if (main_pos) begin
                        state_in = F_SQRT;
                     end else begin
                        done_in = 1'b1;
                     end
                  end
                  vds_pkg::MODE_MANHATTAN: begin
                     if (main_pos) begin
                        dist_in = (main_sum > {22'b0, vds_pkg::DIST_MAX}) ?
                                  vds_pkg::DIST_MAX : main_sum[vds_pkg::DIST_W-1:0];
                     end
                     done_in = 1'b1;
                  end
                  default: begin
                     rad_in   = {square_sum_a, 43'b0};
                     den_in   = {1'b0, square_sum_b};
                     cnt_in   = 6'd40;
                     state_in = F_MUL;
                  end
               endcase
            end
         end
         F_MUL: begin
            acc_in = alu_sum[AW-1:0];
            rad_in = {rad_ff[AW-2:0], 1'b0};
            if (cnt_ff == '0) begin
               // The product now becomes the radicand of the root.
               rad_in   = alu_sum[AW-1:0];
               acc_in   = '0;
               root_in  = '0;
               cnt_in   = 6'd41;
               state_in = F_SQRT;
            end
         end
         F_SQRT: begin
            acc_in  = alu_ok ? alu_sum[AW-1:0] : op_a;
            root_in = root_next;
            rad_in  = {rad_ff[AW-3:0], 2'b00};
            if (cnt_ff == '0) begin
               if (mode_ff != vds_pkg::MODE_COSINE) begin
                  dist_in  = root_next[vds_pkg::DIST_W-1:0];
                  done_in  = 1'b1;
                  state_in = F_IDLE;
               end else if (root_next == '0) begin
                  zn_in    = 1'b1;
                  done_in  = 1'b1;
                  state_in = F_IDLE;
               end else begin
                  den_in    = root_next;
                  rad_in    = {mag_ff, 16'b0, 20'b0};
                  acc_in    = '0;
                  root_in   = '0;
                  sticky_in = 1'b0;
                  cnt_in    = 6'd63;
                  state_in  = F_DIV;
               end
            end
         end
         F_DIV: begin
            acc_in    = alu_ok ? alu_sum[AW-1:0] : op_a;
            root_in   = root_next;
            sticky_in = sticky_ff | root_ff[RW-1];
            rad_in    = {rad_ff[AW-2:0], 1'b0};
            if (cnt_ff == '0) begin
               sim_in   = neg_ff ? -{1'b0, q_clamp} : {1'b0, q_clamp};
               done_in  = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      den_ff    <= den_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      sticky_ff <= sticky_in;
      cnt_ff    <= cnt_in;
      mode_ff   <= mode_in;
      zn_ff     <= zn_in;
      dist_ff   <= dist_in;
      sim_ff    <= sim_in;
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign fin_rsp.done       = done_ff;
   assign fin_rsp.distance   = dist_ff;
   assign fin_rsp.similarity = sim_ff;
   assign fin_rsp.zero_norm  = zn_ff;

endmodule

`default_nettype wire

@@ src/vector_distance_similarity_top.sv @@
// ----------------------------------------------------------------------------
// vector_distance_similarity_top
// Norm, Euclidean, Manhattan and cosine measures over streamed element pairs.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req_     in         valid / stall      elem_a, elem_b, last_elem
//  rsp_     out        valid / stall      distance, similarity, zero_norm
//  csr_     in         valid / ready      metric_mode
//
// Each element request runs through the load, the multiplier's three passes,
// the final sum update and the return to idle before the next is accepted.
// A result then goes through the finish unit: Manhattan needs no iteration, a
// root runs its digit steps, and cosine runs multiply, root and divide steps on
// the one adder. Reset is synchronous and clears all sums.
// A result waiting for the output register blocks the next request; one held
// in the output register under output stall does not.
`default_nettype none

module vector_distance_similarity_top #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int ELEM_BITS    = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [vds_pkg::ELEM_W-1:0] req_elem_a,
   input  wire logic signed [vds_pkg::ELEM_W-1:0] req_elem_b,
   input  wire logic                              req_last_elem,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [vds_pkg::DIST_W-1:0]             rsp_distance,
   output logic signed [vds_pkg::SIM_W-1:0]       rsp_similarity,
   output logic                                   rsp_zero_norm,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [vds_pkg::MODE_W-1:0]        csr_metric_mode
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ACCUM  = 4'b0010,
      S_FINISH = 4'b0100,
      S_WAIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [vds_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_next;
   logic last_ff, last_in, accept, acc_done, acc_clear, out_free, load;
   logic rsp_valid_ff, rsp_valid_in;
   logic [vds_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [vds_pkg::SIM_W-1:0] sim_ff, sim_in;
   logic zn_ff, zn_in;
   logic signed [vds_pkg::MAIN_W-1:0] main_sum;
   logic [vds_pkg::SQ_W-1:0] sqa, sqb;
   vds_pkg::fin_req_type fin_req;
   vds_pkg::fin_rsp_type fin_rsp;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == S_WAIT) && out_free;

   assign fin_req.start = (state_ff == S_ACCUM) && acc_done && last_ff;
   assign fin_req.mode  = mode_ff;
   assign acc_clear     = fin_req.start;

   vds_accum #(
      .ELEM_BITS(ELEM_BITS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .clear        (acc_clear),
      .mode         (mode_ff),
      .elem_a       (req_elem_a),
      .elem_b       (req_elem_b),
      .done         (acc_done),
      .main_sum     (main_sum),
      .square_sum_a (sqa),
      .square_sum_b (sqb)
   );

   vds_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .fin_req      (fin_req),
      .main_sum     (main_sum),
      .square_sum_a (sqa),
      .square_sum_b (sqb),
      .fin_rsp      (fin_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dist_in      = dist_ff;
      sim_in       = sim_ff;
      zn_in        = zn_ff;
      if (csr_valid && csr_ready) begin
         mode_in = csr_metric_mode;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // A full vector closes the request even without the mark.
               last_in  = req_last_elem || (cnt_next >= CNT_W'(MAX_ELEMENTS));
               cnt_in   = last_in ? '0 : cnt_next;
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (acc_done) begin
               state_in = last_ff ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            if (fin_rsp.done) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               dist_in      = fin_rsp.distance;
               sim_in       = fin_rsp.similarity;
               zn_in        = fin_rsp.zero_norm;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      dist_ff <= dist_in;
      sim_ff  <= sim_in;
      zn_ff   <= zn_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= vds_pkg::MODE_NORM;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = dist_ff;
   assign rsp_similarity = sim_ff;
   assign rsp_zero_norm  = zn_ff;

   a_start_after_accum: assert property (@(posedge clock) disable iff (reset)
      fin_req.start |=> (state_ff == S_FINISH))
      else $error("finish unit started outside the accumulate step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending result overwritten");

   a_zero_norm_sim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_norm) |-> (rsp_similarity == '0 && rsp_distance == '0))
      else $error("zero norm result carries a value");

   a_stall_while_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && last_in) |=> req_stall ##1 req_stall)
      else $error("request taken while a vector is being finished");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector distance engine: streams element pairs
// under random idling and output stalls, predicts each metric result in the
// bench and compares every field of every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   localparam int  MAX_ELEMS   = 1024;
   localparam int  SETTLE_CYC  = 200;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam longint MAIN_HI  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint MAIN_LO  = -MAIN_HI - 1;
   localparam longint SQ_TOP   = 64'h0000_01FF_FFFF_FFFF;
   localparam longint DIST_TOP = 64'h0000_0000_03FF_FFFF;

   typedef struct packed {
      logic [vds_pkg::DIST_W-1:0] distance;
      logic [vds_pkg::SIM_W-1:0]  similarity;
      logic                       zero_norm;
   } metric_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [vds_pkg::ELEM_W-1:0] req_elem_a = '0;
   logic signed [vds_pkg::ELEM_W-1:0] req_elem_b = '0;
   logic                              req_last_elem = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [vds_pkg::DIST_W-1:0]        rsp_distance;
   logic signed [vds_pkg::SIM_W-1:0]  rsp_similarity;
   logic                              rsp_zero_norm;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [vds_pkg::MODE_W-1:0]        csr_metric_mode = '0;

   // Bench copy of the engine state
   logic [vds_pkg::MODE_W-1:0] cur_mode;
   longint            acc_main;
   longint            acc_sq_a;
   longint            acc_sq_b;
   int                elem_seen;

   metric_result_type pending_results[$];
   int                mismatches = 0;
   int                cycles = 0;
   int                burst_left = 0;
   int                gap_max = 0;
   int                stall_pct = 0;
   int                hold_req = 0;
   int                hold_cnt = 0;

   vector_distance_similarity_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_elem_a      (req_elem_a),
      .req_elem_b      (req_elem_b),
      .req_last_elem   (req_last_elem),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance    (rsp_distance),
      .rsp_similarity  (rsp_similarity),
      .rsp_zero_norm   (rsp_zero_norm),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_metric_mode (csr_metric_mode)
   );

   always #5 clock = ~clock;

   function automatic longint floor_root(input longint v);
      longint r, t;
      r = 0;
      for (int bit_i = 24; bit_i >= 0; bit_i--) begin
         t = r | (64'sd1 << bit_i);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic logic [127:0] floor_root_prod(input longint x, input longint y);
      logic [127:0] prod, r, t;
      prod = {64'b0, x} * {64'b0, y};
      r = '0;
      for (int bit_i = 42; bit_i >= 0; bit_i--) begin
         t = r | (128'd1 << bit_i);
         if (t * t <= prod) r = t;
      end
      return r;
   endfunction

   // Folds one accepted element into the bench state; returns 1 when a result
   // is due and fills res.
   function automatic bit accumulate_elem(input logic signed [vds_pkg::ELEM_W-1:0] a,
                                          input logic signed [vds_pkg::ELEM_W-1:0] b,
                                          input logic last,
                                          output metric_result_type res);
      longint       av, bv, d, term, dist_val, mag;
      logic [127:0] den;
      logic [79:0]  quot;
      bit           done;
      av = a;
      bv = b;
      d = av - bv;
      res = '0;
      dist_val = 0;
      acc_sq_a = (acc_sq_a + av * av > SQ_TOP) ? SQ_TOP : acc_sq_a + av * av;
      acc_sq_b = (acc_sq_b + bv * bv > SQ_TOP) ? SQ_TOP : acc_sq_b + bv * bv;
      if (cur_mode == vds_pkg::MODE_EUCLIDEAN) term = d * d;
      else if (cur_mode == vds_pkg::MODE_MANHATTAN) term = (d < 0) ? -d : d;
      else term = av * bv;
      acc_main = acc_main + term;
      if (acc_main > MAIN_HI) acc_main = MAIN_HI;
      if (acc_main < MAIN_LO) acc_main = MAIN_LO;
      elem_seen++;
      done = last || (elem_seen >= MAX_ELEMS);
      if (!done) return 1'b0;
      case (cur_mode)
         vds_pkg::MODE_NORM: begin
            dist_val = floor_root(acc_sq_a);
         end
         vds_pkg::MODE_EUCLIDEAN: begin
            dist_val = (acc_main > 0) ? floor_root(acc_main) : 0;
         end
         vds_pkg::MODE_MANHATTAN: begin
            dist_val = (acc_main > 0) ? acc_main : 0;
         end
         default: begin
            den = floor_root_prod(acc_sq_a, acc_sq_b);
            if (den == 0) begin
               res.zero_norm = 1'b1;
            end else begin
               mag = (acc_main < 0) ? -acc_main : acc_main;
               quot = ({16'b0, mag} << 16) / den[79:0];
               if (quot > {63'b0, vds_pkg::ONE_Q16}) quot = {63'b0, vds_pkg::ONE_Q16};
               if (acc_main < 0) quot = -quot;
               res.similarity = quot[vds_pkg::SIM_W-1:0];
            end
         end
      endcase
      if (dist_val > DIST_TOP) dist_val = DIST_TOP;
      res.distance = dist_val[vds_pkg::DIST_W-1:0];
      acc_main = 0;
      acc_sq_a = 0;
      acc_sq_b = 0;
      elem_seen = 0;
      return 1'b1;
   endfunction

   // Offers one request and waits for the edge that accepts it. Valid is left
   // high, unless a random idle gap follows, so that a following request continues without a gap.
   task automatic send_elem(input logic signed [vds_pkg::ELEM_W-1:0] a,
                            input logic signed [vds_pkg::ELEM_W-1:0] b,
                            input logic last);
      metric_result_type res;
      int                gap;
      req_valid     <= 1'b1;
      req_elem_a    <= a;
      req_elem_b    <= b;
      req_last_elem <= last;
      do @(posedge clock); while (req_stall);
      if (accumulate_elem(a, b, last, res)) pending_results = {pending_results, res};
      if (gap_max > 0) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, gap_max);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drops valid, waits for every outstanding result and lets the finish
   // unit settle, so that the engine is idle afterwards.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_mode(input logic [vds_pkg::MODE_W-1:0] mode);
      csr_valid       <= 1'b1;
      csr_metric_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      cur_mode = mode;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [vds_pkg::ELEM_W-1:0] pick_elem();
      int raw;
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: begin
            raw = $urandom_range(0, 15) - 8;
            return raw[vds_pkg::ELEM_W-1:0];
         end
         default: begin
            raw = $urandom;
            return raw[vds_pkg::ELEM_W-1:0];
         end
      endcase
   endfunction

   // Results and output stalls
   always @(posedge clock) begin
      metric_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: dist %0d sim %0d zn %0d",
                        rsp_distance, rsp_similarity, rsp_zero_norm);
         end else begin
            want = pending_results.pop_front();
            if (rsp_distance !== want.distance || rsp_similarity !== want.similarity ||
                rsp_zero_norm !== want.zero_norm) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: dist %0d/%0d sim %0d/%0d zn %0d/%0d (exp/act)",
                           want.distance, rsp_distance, $signed(want.similarity),
                           rsp_similarity, want.zero_norm, rsp_zero_norm);
            end
         end
      end
      rsp_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < stall_pct) ||
                   (stall_pct > 0 && cycles % 23 < 3);
   end

   // Long receiver hold-off, counted here in cycles
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_cnt <= hold_req;
         hold_req = 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_extremes();
      for (int m = 0; m < 4; m++) begin
         write_mode(m[vds_pkg::MODE_W-1:0]);
         send_elem(16'sh7FFF, 16'sh8000, 1'b0);
         send_elem(16'sh8000, 16'sh7FFF, 1'b0);
         send_elem(16'sh8000, 16'sh8000, 1'b1);
         wait_idle();
      end
   endtask

   task automatic test_cosine_cases();
      // zero norm, parallel and opposed vectors
      send_elem('0, 16'sd5, 1'b1);
      send_elem(16'sd300, 16'sd600, 1'b0);
      send_elem(-16'sd70, -16'sd140, 1'b1);
      send_elem(16'sd1234, -16'sd1234, 1'b1);
      wait_idle();
   endtask

   task automatic test_mode_change_in_vector();
      // a negative product sum read as a Euclidean sum gives distance zero
      send_elem(16'sd1000, -16'sd1000, 1'b0);
      wait_idle();
      write_mode(vds_pkg::MODE_EUCLIDEAN);
      send_elem('0, '0, 1'b1);
      wait_idle();
   endtask

   task automatic test_forced_last();
      // no last mark: the element limit closes the vector, and the
      // Manhattan sum comes close to the top of the distance field
      write_mode(vds_pkg::MODE_MANHATTAN);
      for (int i = 0; i < MAX_ELEMS; i++) send_elem(16'sh7FFF, 16'sh8000, 1'b0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      hold_req = 3000;
      write_mode(vds_pkg::MODE_COSINE);
      for (int i = 0; i < 40; i++) send_elem(pick_elem(), pick_elem(), 1'b1);
      wait_idle();
   endtask

   task automatic test_random();
      int                                len;
      int                                sent;
      int                                rnd_word;
      logic [vds_pkg::MODE_W-1:0]        mode_sel;
      logic signed [vds_pkg::ELEM_W-1:0] a, b;
      for (int phase = 0; phase < 8; phase++) begin
         rnd_word = $urandom_range(0, 3);
         mode_sel = (phase < 4) ? phase[vds_pkg::MODE_W-1:0]
                                : rnd_word[vds_pkg::MODE_W-1:0];
         write_mode(mode_sel);
         gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
         stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 60);
         sent = 0;
         while (sent < 90) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               a = pick_elem();
               case ($urandom_range(0, 5))
                  0: b = a;
                  1: b = -a;
                  default: b = pick_elem();
               endcase
               // the final phase boundary may cut a vector in two
               send_elem(a, b, i == len - 1 && !(sent >= 85 && phase % 2 == 1));
               sent++;
            end
         end
         wait_idle();
      end
      gap_max = 0;
      stall_pct = 0;
   endtask

   initial begin
      cur_mode = vds_pkg::MODE_NORM;
      acc_main = 0;
      acc_sq_a = 0;
      acc_sq_b = 0;
      elem_seen = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_cosine_cases();
      test_mode_change_in_vector();
      test_forced_last();
      test_backpressure();
      test_random();
      wait_idle();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/vds_pkg.sv
src/vds_accum.sv
src/vds_finish.sv
src/vector_distance_similarity_top.sv
verif/tb_top.sv
